@@ hw/rtl/fhs_pkg.sv @@
// fhs_pkg: item types and shared constants of the frame hit stitcher
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package fhs_pkg;

  localparam int TS_W        = 63;
  localparam int TICK_W      = 6;
  localparam int AMP_W       = 16;
  localparam int FRAG_SUM_W  = 24;
  localparam int SUM_W       = 32;
  localparam int DUR_W       = 32;
  localparam int CHAN_W      = 16;

  localparam int TICK_SCALE  = 32;
  localparam int FRAME_TICKS = 64;
  localparam int OUT_DEPTH   = 4;

  typedef struct packed {
    logic [TS_W-1:0]       frame_timestamp;
    logic [TICK_W-1:0]     start_tick;
    logic [TICK_W-1:0]     end_tick;
    logic [TICK_W-1:0]     peak_tick;
    logic [AMP_W-1:0]      peak_value;
    logic [FRAG_SUM_W-1:0] fragment_sum;
    logic                  continues;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0]   hit_start;
    logic [TS_W-1:0]   hit_peak_time;
    logic [DUR_W-1:0]  hit_duration;
    logic [CHAN_W-1:0] hit_channel;
    logic [SUM_W-1:0]  hit_sum;
    logic [AMP_W-1:0]  hit_peak_value;
    logic              last;
  } out_item_t;

  // results of one merge step, item0 first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } emit_t;

endpackage

@@ hw/rtl/fhs_in_reg.sv @@
// fhs_in_reg: input register holding one fragment for the merge stage
// depends on fhs_pkg for the input item type
`timescale 1ns / 1ps

module fhs_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fhs_pkg::in_item_t  in_data,
  output logic               frag_valid,
  output fhs_pkg::in_item_t  frag,
  input  logic               consume
);

  logic accept;

  assign in_stall = frag_valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_valid <= 1'b0;
    end else if (accept) begin
      frag_valid <= 1'b1;
    end else if (consume) begin
      frag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frag <= in_data;
    end
  end

endmodule

@@ hw/rtl/fhs_merge.sv @@
// fhs_merge: pending hit state, channel register and the stitch decision
// depends on fhs_pkg for item types and field widths
`timescale 1ns / 1ps

module fhs_merge #(
  parameter int TICK_SCALE  = fhs_pkg::TICK_SCALE,
  parameter int FRAME_TICKS = fhs_pkg::FRAME_TICKS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [fhs_pkg::CHAN_W-1:0]  cfg_wr_data,
  input  logic                        frag_valid,
  input  fhs_pkg::in_item_t           frag,
  input  logic                        room,
  output logic                        consume,
  output fhs_pkg::emit_t              emit
);

  localparam int OFF_W = $clog2((2**fhs_pkg::TICK_W) * TICK_SCALE + 1);
  localparam logic [fhs_pkg::TS_W-1:0] FRAME_GAP = fhs_pkg::TS_W'(TICK_SCALE * FRAME_TICKS);
  localparam int MAX_SUM = fhs_pkg::SUM_W;

  logic [fhs_pkg::CHAN_W-1:0] channel_id;
  logic                       open_hit;
  logic [fhs_pkg::TS_W-1:0]   previous_frame_time;
  logic [fhs_pkg::TS_W-1:0]   pending_start;
  logic [fhs_pkg::TS_W-1:0]   pending_end;
  logic [fhs_pkg::TS_W-1:0]   pending_peak_time;
  logic [fhs_pkg::AMP_W-1:0]  pending_peak_value;
  logic [fhs_pkg::SUM_W-1:0]  pending_sum;

  logic                       split;
  logic                       extend;
  logic                       stays_open;
  logic [fhs_pkg::TS_W-1:0]   gap;
  logic [fhs_pkg::TS_W-1:0]   start_abs;
  logic [fhs_pkg::TS_W-1:0]   end_abs;
  logic [fhs_pkg::TS_W-1:0]   peak_abs;
  logic [fhs_pkg::TS_W-1:0]   start_next;
  logic [fhs_pkg::TS_W-1:0]   peak_time_next;
  logic [fhs_pkg::AMP_W-1:0]  peak_value_next;
  logic [fhs_pkg::SUM_W-1:0]  base_sum;
  logic [MAX_SUM:0]           sum_wide;
  logic [fhs_pkg::SUM_W-1:0]  sum_next;
  fhs_pkg::out_item_t         old_item;
  fhs_pkg::out_item_t         new_item;

  function automatic logic [fhs_pkg::TS_W-1:0] abs_time(
    input logic [fhs_pkg::TS_W-1:0]   ts,
    input logic [fhs_pkg::TICK_W-1:0] tick
  );
    logic [OFF_W-1:0] off;
    off = OFF_W'(tick) * OFF_W'(TICK_SCALE);
    return ts + fhs_pkg::TS_W'(off);
  endfunction

  function automatic logic [fhs_pkg::DUR_W-1:0] duration(
    input logic [fhs_pkg::TS_W-1:0] t_end,
    input logic [fhs_pkg::TS_W-1:0] t_start
  );
    logic [fhs_pkg::TS_W-1:0] diff;
    diff = t_end - t_start;
    if (t_end < t_start) begin
      return '0;
    end else if (|diff[fhs_pkg::TS_W-1:fhs_pkg::DUR_W]) begin
      return '1;
    end else begin
      return diff[fhs_pkg::DUR_W-1:0];
    end
  endfunction

  assign consume = frag_valid && room;

  always_comb begin
    gap        = frag.frame_timestamp - previous_frame_time;
    split      = open_hit && ((gap != FRAME_GAP) || (frag.start_tick != '0));
    extend     = open_hit && !split;
    stays_open = frag.continues && (int'(frag.end_tick) == FRAME_TICKS - 1);

    start_abs = abs_time(frag.frame_timestamp, frag.start_tick);
    end_abs   = abs_time(frag.frame_timestamp, frag.end_tick);
    peak_abs  = abs_time(frag.frame_timestamp, frag.peak_tick);

    start_next = extend ? pending_start : start_abs;
    base_sum   = extend ? pending_sum : '0;
    sum_wide   = {1'b0, base_sum} + (MAX_SUM + 1)'(frag.fragment_sum);
    sum_next   = sum_wide[MAX_SUM] ? '1 : sum_wide[MAX_SUM-1:0];

    // strictly higher peak wins, earliest peak kept on ties
    if (extend && !(frag.peak_value > pending_peak_value)) begin
      peak_time_next  = pending_peak_time;
      peak_value_next = pending_peak_value;
    end else begin
      peak_time_next  = peak_abs;
      peak_value_next = frag.peak_value;
    end

    old_item.hit_start      = pending_start;
    old_item.hit_peak_time  = pending_peak_time;
    old_item.hit_duration   = duration(pending_end, pending_start);
    old_item.hit_channel    = channel_id;
    old_item.hit_sum        = pending_sum;
    old_item.hit_peak_value = pending_peak_value;
    old_item.last           = stays_open;

    new_item.hit_start      = start_next;
    new_item.hit_peak_time  = peak_time_next;
    new_item.hit_duration   = duration(end_abs, start_next);
    new_item.hit_channel    = channel_id;
    new_item.hit_sum        = sum_next;
    new_item.hit_peak_value = peak_value_next;
    new_item.last           = 1'b1;

    emit.item0 = split ? old_item : new_item;
    emit.item1 = new_item;
    if (!consume) begin
      emit.count = 2'd0;
    end else begin
      emit.count = 2'({1'b0, split}) + 2'({1'b0, !stays_open});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_id <= '0;
    end else if (cfg_wr_en) begin
      channel_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_hit <= 1'b0;
    end else if (consume) begin
      open_hit <= stays_open;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      previous_frame_time <= frag.frame_timestamp;
      pending_start       <= start_next;
      pending_end         <= end_abs;
      pending_peak_time   <= peak_time_next;
      pending_peak_value  <= peak_value_next;
      pending_sum         <= sum_next;
    end
  end

endmodule

@@ hw/rtl/fhs_out_fifo.sv @@
// fhs_out_fifo: small result queue taking up to two items per cycle
// depends on fhs_pkg for the result item and emit types
`timescale 1ns / 1ps

module fhs_out_fifo #(
  parameter int DEPTH = fhs_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  fhs_pkg::emit_t      emit,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output fhs_pkg::out_item_t  out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fhs_pkg::out_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               pop;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    if (int'(p) == DEPTH - 1) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  assign room      = int'(count) <= DEPTH - 2;
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_1  = inc(wr_ptr);

  always_comb begin
    unique case (emit.count)
      2'd0:    wr_ptr_next = wr_ptr;
      2'd1:    wr_ptr_next = wr_ptr_1;
      default: wr_ptr_next = inc(wr_ptr_1);
    endcase
    count_next = count + CNT_W'(emit.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.count != 2'd0) begin
      mem[wr_ptr] <= emit.item0;
    end
    if (emit.count == 2'd2) begin
      mem[wr_ptr_1] <= emit.item1;
    end
  end

endmodule

@@ hw/rtl/frame_hit_stitcher.sv @@
// frame_hit_stitcher: top level joining per-frame hit fragments into hits
// depends on fhs_pkg, fhs_in_reg, fhs_merge and fhs_out_fifo
//
// usage:
//   in_valid / in_stall / in_data carry one fragment item per accepted edge
//   out_valid / out_stall / out_data carry stitched hit items
//   cfg_wr_en / cfg_wr_data write the channel number, only while idle
//   a fragment gives zero, one or two hits; last marks the final one
//   a fragment waits in the input register until the merge queues its hits
//   throughput: one fragment per cycle while the queue has room, set
//   by the single merge stage; the output side moves one hit per cycle
//   unless out_stall is high, and fragments that split an open hit and
//   close their own put two hits in the result queue
//   the merge step waits until the result queue has room for two hits
//   a stalled receiver fills the queue, then in_stall rises
//   reset clears the open hit, the channel number and the queue
//   a hit still open when input ends stays pending
`timescale 1ns / 1ps

module frame_hit_stitcher #(
  parameter int TICK_SCALE  = fhs_pkg::TICK_SCALE,
  parameter int FRAME_TICKS = fhs_pkg::FRAME_TICKS,
  parameter int OUT_DEPTH   = fhs_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fhs_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fhs_pkg::out_item_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [fhs_pkg::CHAN_W-1:0]  cfg_wr_data
);

  logic              frag_valid;
  fhs_pkg::in_item_t frag;
  logic              consume;
  logic              room;
  fhs_pkg::emit_t    emit;

  fhs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .frag_valid (frag_valid),
    .frag       (frag),
    .consume    (consume)
  );

  fhs_merge #(
    .TICK_SCALE  (TICK_SCALE),
    .FRAME_TICKS (FRAME_TICKS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .frag_valid  (frag_valid),
    .frag        (frag),
    .room        (room),
    .consume     (consume),
    .emit        (emit)
  );

  fhs_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
